// ----- sv/mvf_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and codes of the mother vertex finder.
package mvf_pkg;

	localparam int MAX_VERTICES_DEF = 64;

	localparam int MODE_W   = 2;
	localparam int VERTEX_W = 6;
	localparam int VCOUNT_W = 7;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIND  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

endpackage

// ----- sv/mvf_adj_mem.sv -----
`timescale 1ns / 1ps
// Adjacency row memory with per-row valid bits, bit writes and a clear of every row at once.
module mvf_adj_mem #(
	parameter int MAX_VERTICES = mvf_pkg::MAX_VERTICES_DEF,
	parameter int VW           = $clog2(MAX_VERTICES)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [VW-1:0]           wr_row,
	input  logic [VW-1:0]           wr_col,
	input  logic                    clr,
	input  logic                    rd_en,
	input  logic [VW-1:0]           rd_row,
	output logic [MAX_VERTICES-1:0] rd_data
);
	import mvf_pkg::*;

	logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_valid_q;
	logic [MAX_VERTICES-1:0] rd_data_s1;
	logic                    rd_valid_s1;

	// A row that was never written since reset or the last clear reads as empty,
	// so its first write fills the whole row instead of a single bit.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int b = 0; b < MAX_VERTICES; b++) begin
				if (!row_valid_q[wr_row] || (VW'(b) == wr_col)) begin
					mem[wr_row][b] <= (VW'(b) == wr_col);
				end
			end
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (clr) begin
				row_valid_q <= '0;
			end else if (wr_en) begin
				row_valid_q[wr_row] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= row_valid_q[rd_row];
			end
		end
	end

	assign rd_data = rd_valid_s1 ? rd_data_s1 : '0;

endmodule

// ----- sv/mother_vertex_finder.sv -----
`timescale 1ns / 1ps
// Top level of the mother vertex finder: command decode, walk sequencer and result.
//
// Usage. An item is accepted on a rising edge with start high and busy low.
// mode selects the command: add edge sets the bit from_vertex -> to_vertex in
// the adjacency memory, clear empties the whole graph, find searches for a
// mother vertex. Add and clear give no result, so busy stays low and a new
// beat can follow every cycle. A find raises busy and later gives one
// result beat: done is high for exactly one cycle with mother_vertex and found
// valid. The receiver cannot stall; the result is gone after that cycle.
// vertex_count is written over its own valid/ready channel (ready is always high)
// and must only be changed while the block is idle; the block does not enforce it.
// With vertex_count zero a find reports on the next cycle. Otherwise it
// walks from every unreached vertex in index order, then once more from the last
// start. Each walk sweeps a pointer from vertex zero round the vertices in use,
// one per cycle, reading each pending row through the single memory read port;
// a row that turns pending behind the pointer waits up to one lap.
// Reset. The graph is empty, vertex_count is 64 and the block is idle at once;
// per-row valid bits make the memory read as empty with no clearing pass.
module mother_vertex_finder #(
	parameter int MAX_VERTICES = mvf_pkg::MAX_VERTICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [mvf_pkg::MODE_W-1:0]    mode,
	input  logic [mvf_pkg::VERTEX_W-1:0]  from_vertex,
	input  logic [mvf_pkg::VERTEX_W-1:0]  to_vertex,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mvf_pkg::VCOUNT_W-1:0]  vertex_count,
	output logic                          done,
	output logic [mvf_pkg::VERTEX_W-1:0]  mother_vertex,
	output logic                          found
);
	import mvf_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int XW = (CW > VCOUNT_W) ? CW : VCOUNT_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SEL   = 2'd1;
	localparam logic [1:0] ST_WALK1 = 2'd2;
	localparam logic [1:0] ST_WALK2 = 2'd3;

	logic [1:0]              state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           v_q;
	logic [VW-1:0]           ptr_q;
	logic [VW-1:0]           cand_q;
	logic [MAX_VERTICES-1:0] reached_q;
	logic [MAX_VERTICES-1:0] pending_q;
	logic                    rd_s1;
	logic                    done_q;
	logic                    found_q;
	logic [VERTEX_W-1:0]     mother_q;

	logic [MAX_VERTICES-1:0] live;
	logic [MAX_VERTICES-1:0] row_data;
	logic [MAX_VERTICES-1:0] new_bits;
	logic [MAX_VERTICES-1:0] issue_bit;
	logic [MAX_VERTICES-1:0] cand_bit;
	logic [MAX_VERTICES-1:0] v_bit;
	logic                    accept;
	logic                    edge_ok;
	logic                    issue;
	logic                    walk_done;
	logic                    all_reached;
	logic [VW-1:0]           from_idx;
	logic [VW-1:0]           to_idx;
	logic [VW-1:0]           ptr_next;
	logic [XW-1:0]           cfg_ext;
	logic [VERTEX_W+VW-1:0]  from_ext;
	logic [VERTEX_W+VW-1:0]  to_ext;
	logic [VERTEX_W+VW-1:0]  cand_ext;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// Vertex indices are resized to the memory index width in both directions.
	assign from_ext = {{VW{1'b0}}, from_vertex};
	assign to_ext   = {{VW{1'b0}}, to_vertex};
	assign cand_ext = {{VERTEX_W{1'b0}}, cand_q};
	assign from_idx = from_ext[VW-1:0];
	assign to_idx   = to_ext[VW-1:0];
	assign edge_ok  = (XW'(from_vertex) < XW'(count_q)) && (XW'(to_vertex) < XW'(count_q));
	assign cfg_ext  = XW'(vertex_count);

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			live[i] = (CW'(i) < count_q);
		end
	end

	// A walk step: the row fetched last cycle adds its unreached live targets to
	// both sets, while the pointer checks one more vertex for a pending row.
	assign new_bits    = row_data & ~reached_q & live & {MAX_VERTICES{rd_s1}};
	assign issue       = pending_q[ptr_q] && ((state_q == ST_WALK1) || (state_q == ST_WALK2));
	assign issue_bit   = issue ? (MAX_VERTICES'(1) << ptr_q) : '0;
	assign ptr_next    = ((CW'(ptr_q) + CW'(1)) >= count_q) ? '0 : (ptr_q + VW'(1));
	assign walk_done   = (pending_q == '0) && !rd_s1;
	assign all_reached = &(reached_q | ~live);
	assign cand_bit    = MAX_VERTICES'(1) << cand_q;
	assign v_bit       = MAX_VERTICES'(1) << v_q[VW-1:0];

	mvf_adj_mem #(
		.MAX_VERTICES(MAX_VERTICES),
		.VW          (VW)
	) u_adj_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && (mode == MODE_ADD) && edge_ok),
		.wr_row (from_idx),
		.wr_col (to_idx),
		.clr    (accept && (mode == MODE_CLEAR)),
		.rd_en  (issue),
		.rd_row (ptr_q),
		.rd_data(row_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= CW'(VCOUNT_RESET > MAX_VERTICES ? MAX_VERTICES : VCOUNT_RESET);
			v_q       <= '0;
			ptr_q     <= '0;
			cand_q    <= '0;
			reached_q <= '0;
			pending_q <= '0;
			rd_s1     <= 1'b0;
			done_q    <= 1'b0;
			found_q   <= 1'b0;
			mother_q  <= '0;
		end else begin
			// The result beat follows either a find with no vertices in use or the
			// end of the second walk.
			done_q <= (accept && (mode == MODE_FIND) && (count_q == '0)) ||
			          ((state_q == ST_WALK2) && walk_done);
			rd_s1  <= issue;
			if (cfg_valid && cfg_ready) begin
				count_q <= (cfg_ext > XW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
				                                          : cfg_ext[CW-1:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (mode == MODE_FIND)) begin
						if (count_q == '0) begin
							found_q  <= 1'b0;
							mother_q <= '0;
						end else begin
							reached_q <= '0;
							pending_q <= '0;
							v_q       <= '0;
							state_q   <= ST_SEL;
						end
					end
				end
				ST_SEL: begin
					ptr_q <= '0;
					if (v_q == count_q) begin
						// First pass over; walk again from the last start alone.
						reached_q <= cand_bit;
						pending_q <= cand_bit;
						state_q   <= ST_WALK2;
					end else begin
						v_q <= v_q + CW'(1);
						if (!reached_q[v_q[VW-1:0]]) begin
							reached_q <= reached_q | v_bit;
							pending_q <= pending_q | v_bit;
							cand_q    <= v_q[VW-1:0];
							state_q   <= ST_WALK1;
						end
					end
				end
				ST_WALK1, ST_WALK2: begin
					reached_q <= reached_q | new_bits;
					pending_q <= (pending_q | new_bits) & ~issue_bit;
					ptr_q     <= ptr_next;
					if (walk_done) begin
						if (state_q == ST_WALK1) begin
							state_q <= ST_SEL;
						end else begin
							found_q  <= all_reached;
							mother_q <= all_reached ? cand_ext[VERTEX_W-1:0] : '0;
							state_q  <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign found         = found_q;
	assign mother_vertex = mother_q;

	// No row fetch may still be in flight once the block reports idle.
	a_idle_no_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !rd_s1)
		else $error("row fetch in flight while idle");

	// A pending vertex has always been marked reached.
	a_pending_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q & ~reached_q) == '0)
		else $error("pending vertex not in reached set");

	// During a search only vertices in use are ever reached.
	a_reached_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> ((reached_q & ~live) == '0))
		else $error("vertex beyond count reached");

endmodule

// ----- tb/mother_vertex_finder_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the mother vertex finder: directed table, then random graph traffic.
module mother_vertex_finder_tb;
	import mvf_pkg::*;

	// The package names the three live modes; the fourth code does nothing in the block.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam int N_VERT        = MAX_VERTICES_DEF;
	localparam int ITEM_TARGET   = 1350;
	localparam int FIND_TARGET   = 40;
	// Cycles allowed after the last result beat for add or clear beats still in flight.
	localparam int SETTLE_CYCLES = 8;

	// One result beat of a find, as the checker compares it.
	typedef struct packed {
		logic [VERTEX_W-1:0] mother_vertex;
		logic                found;
	} search_result_t;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	// A row of the directed table: either a vertex_count write or one command beat.
	// Where typed is set the row carries its own expected result.
	typedef struct packed {
		row_kind_t           kind;
		logic [MODE_W-1:0]   mode;
		logic [VERTEX_W-1:0] from_vertex;
		logic [VERTEX_W-1:0] to_vertex;
		logic [VCOUNT_W-1:0] vertex_count;
		logic                typed;
		search_result_t      result;
	} directed_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [MODE_W-1:0]   mode;
	logic [VERTEX_W-1:0] from_vertex;
	logic [VERTEX_W-1:0] to_vertex;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [VCOUNT_W-1:0] vertex_count;
	logic                done;
	logic [VERTEX_W-1:0] mother_vertex;
	logic                found;

	// Shadow copy of the graph and of the register, kept in step with accepted beats.
	logic [N_VERT-1:0]   graph_rows [N_VERT];
	logic [VCOUNT_W-1:0] shadow_vcount;

	// Results of accepted finds that have not yet come out, oldest first.
	search_result_t      pending_searches [$];
	directed_row_t       directed_rows [$];

	int errors;
	int items_sent;
	int finds_sent;
	int sender_idle_pct;

	mother_vertex_finder #(
		.MAX_VERTICES(N_VERT)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.from_vertex  (from_vertex),
		.to_vertex    (to_vertex),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.vertex_count (vertex_count),
		.done         (done),
		.mother_vertex(mother_vertex),
		.found        (found)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit. A correct run stays far below this even if every beat were a find
	// on a 64-vertex chain against the index order.
	initial begin
		#200_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Set of vertices reachable from root, confined to the vertices in use.
	// Walk order inside the block does not matter, only the closure does.
	function automatic logic [N_VERT-1:0] reach_from(int unsigned root,
			logic [N_VERT-1:0] in_use);
		logic [N_VERT-1:0] reached;
		logic [N_VERT-1:0] grown;
		grown = '0;
		grown[root] = 1'b1;
		do begin
			reached = grown;
			for (int v = 0; v < N_VERT; v++)
				if (reached[v])
					grown |= graph_rows[v] & in_use;
		end while (grown != reached);
		return reached;
	endfunction

	// Expected outcome of a find on the shadow graph. The first pass starts a walk
	// at every vertex not yet reached, in index order, and keeps the last start as
	// the candidate. The candidate is reported only if it alone reaches every
	// vertex in use. A count above the store acts as the full store; a count of
	// zero gives an all-zero result.
	function automatic search_result_t predict_search();
		logic [N_VERT-1:0] in_use;
		logic [N_VERT-1:0] reached;
		int unsigned       live;
		int unsigned       candidate;
		search_result_t    res;
		live = (shadow_vcount > N_VERT) ? N_VERT : shadow_vcount;
		res = '0;
		if (live == 0)
			return res;
		in_use = (live == N_VERT) ? '1 : ((N_VERT'(1) << live) - 1);
		reached = '0;
		candidate = 0;
		for (int v = 0; v < live; v++) begin
			if (!reached[v]) begin
				reached |= reach_from(v, in_use);
				candidate = v;
			end
		end
		if (reach_from(candidate, in_use) == in_use) begin
			res.mother_vertex = candidate[VERTEX_W-1:0];
			res.found = 1'b1;
		end
		return res;
	endfunction

	// Drives one command beat and returns at the falling edge after it is taken.
	// start is left high on return, so the caller either drives the next beat or
	// lowers start at that same falling edge. The shadow state is updated at the
	// accepting edge, so a find is predicted against exactly the graph it sees.
	task automatic send_item(input logic [MODE_W-1:0] m, input logic [VERTEX_W-1:0] f,
			input logic [VERTEX_W-1:0] t, input logic typed, input search_result_t typed_result);
		int unsigned    live;
		search_result_t expected;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start       <= 1'b1;
		mode        <= m;
		from_vertex <= f;
		to_vertex   <= t;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		live = (shadow_vcount > N_VERT) ? N_VERT : shadow_vcount;
		items_sent++;
		case (m)
			MODE_ADD: begin
				// Edges touching a vertex beyond the count are dropped by the block.
				if (f < live && t < live)
					graph_rows[f][t] = 1'b1;
			end
			MODE_CLEAR: begin
				for (int v = 0; v < N_VERT; v++)
					graph_rows[v] = '0;
			end
			MODE_FIND: begin
				expected = typed ? typed_result : predict_search();
				pending_searches = {pending_searches, expected};
				finds_sent++;
			end
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Writes vertex_count once the block has gone quiet: no find outstanding, busy
	// low, and a further SETTLE_CYCLES wait for any add or clear still settling.
	task automatic write_vertex_count(input logic [VCOUNT_W-1:0] value);
		start <= 1'b0;
		while (pending_searches.size() != 0 || busy)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
		cfg_valid    <= 1'b1;
		vertex_count <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		shadow_vcount = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// An add beat, now and then preceded by noise (an unused-mode beat or an edge
	// anywhere in the full field range, usually beyond the count) and now and then
	// repeated to exercise duplicate edges.
	task automatic send_edge(input int unsigned f, input int unsigned t);
		if ($urandom_range(99) < 8) begin
			if ($urandom_range(1))
				send_item(MODE_UNUSED, VERTEX_W'($urandom_range(63)),
					VERTEX_W'($urandom_range(63)), 1'b0, '0);
			else
				send_item(MODE_ADD, VERTEX_W'($urandom_range(63)),
					VERTEX_W'($urandom_range(63)), 1'b0, '0);
		end
		send_item(MODE_ADD, VERTEX_W'(f), VERTEX_W'(t), 1'b0, '0);
		if ($urandom_range(99) < 5)
			send_item(MODE_ADD, VERTEX_W'(f), VERTEX_W'(t), 1'b0, '0);
	endtask

	// One well-formed sequence: usually a clear, then a graph of one of four
	// shapes over the vertices in use, a few loose edges, and one or two finds. Skipping
	// the clear leaves old edges in place, including ones stored under a larger
	// count, which the block must then ignore.
	task automatic build_and_search(input int unsigned live);
		int unsigned order [N_VERT];
		int unsigned pick;
		int unsigned tmp;
		if ($urandom_range(99) < 75)
			send_item(MODE_CLEAR, VERTEX_W'($urandom_range(63)),
				VERTEX_W'($urandom_range(63)), 1'b0, '0);
		if (live == 0) begin
			repeat ($urandom_range(3))
				send_edge($urandom_range(63), $urandom_range(63));
			send_item(MODE_FIND, VERTEX_W'($urandom_range(63)),
				VERTEX_W'($urandom_range(63)), 1'b0, '0);
			return;
		end
		for (int i = 0; i < live; i++)
			order[i] = i;
		for (int i = live - 1; i > 0; i--) begin
			pick = $urandom_range(i);
			tmp = order[i];
			order[i] = order[pick];
			order[pick] = tmp;
		end
		case ($urandom_range(3))
			// Chain through a shuffled order: its head is always a mother vertex.
			0: for (int i = 1; i < live; i++)
				send_edge(order[i-1], order[i]);
			// Chain running down the index order: the slowest case for the walks.
			1: for (int i = 1; i < live; i++)
				send_edge(i, i - 1);
			// Random sparse to medium-dense graph.
			2: repeat ($urandom_range(2 * live))
				send_edge($urandom_range(live - 1), $urandom_range(live - 1));
			// Tree under a random root, with some branches cut off.
			default: for (int i = 1; i < live; i++)
				if ($urandom_range(9) != 0)
					send_edge(order[$urandom_range(i - 1)], order[i]);
		endcase
		repeat ($urandom_range(live / 4))
			send_edge($urandom_range(live - 1), $urandom_range(live - 1));
		send_item(MODE_FIND, VERTEX_W'($urandom_range(63)),
			VERTEX_W'($urandom_range(63)), 1'b0, '0);
		// Sometimes grow the same graph a little and search again.
		if ($urandom_range(99) < 30) begin
			repeat ($urandom_range(1, 3))
				send_edge($urandom_range(live - 1), $urandom_range(live - 1));
			send_item(MODE_FIND, VERTEX_W'($urandom_range(63)),
				VERTEX_W'($urandom_range(63)), 1'b0, '0);
		end
	endtask

	function automatic void table_item(logic [MODE_W-1:0] m, logic [VERTEX_W-1:0] f,
			logic [VERTEX_W-1:0] t);
		directed_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.mode = m;
		row.from_vertex = f;
		row.to_vertex = t;
		directed_rows = {directed_rows, row};
	endfunction

	function automatic void table_find(logic [VERTEX_W-1:0] mv, logic fnd);
		directed_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.mode = MODE_FIND;
		row.typed = 1'b1;
		row.result.mother_vertex = mv;
		row.result.found = fnd;
		directed_rows = {directed_rows, row};
	endfunction

	function automatic void table_cfg(logic [VCOUNT_W-1:0] value);
		directed_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.vertex_count = value;
		directed_rows = {directed_rows, row};
	endfunction

	// Result checker. A result beat is valid for one cycle only and is taken at the
	// rising edge that ends it; it must match the oldest outstanding find.
	always @(posedge clk) begin : check_results
		search_result_t oldest;
		if (arst_n && done) begin
			if (pending_searches.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat: expected none, %s %0d found %0b",
					$time, "got mother_vertex", mother_vertex, found);
			end else begin
				oldest = pending_searches.pop_front();
				if (mother_vertex !== oldest.mother_vertex) begin
					errors++;
					$display("%0t: mother_vertex mismatch: expected %0d, got %0d",
						$time, oldest.mother_vertex, mother_vertex);
				end
				if (found !== oldest.found) begin
					errors++;
					$display("%0t: found mismatch: expected %0b, got %0b",
						$time, oldest.found, found);
				end
			end
		end
	end

	initial begin
		int unsigned directed_items;
		int unsigned random_span;
		int unsigned pick;
		logic [VCOUNT_W-1:0] next_count;

		start        = 1'b0;
		mode         = MODE_ADD;
		from_vertex  = '0;
		to_vertex    = '0;
		cfg_valid    = 1'b0;
		vertex_count = VCOUNT_RESET;
		arst_n       = 1'b0;

		errors = 0;
		items_sent = 0;
		finds_sent = 0;
		sender_idle_pct = 36;
		shadow_vcount = VCOUNT_RESET;
		for (int v = 0; v < N_VERT; v++)
			graph_rows[v] = '0;

		// Directed part. With the reset count of 64 and an empty graph every
		// vertex is its own walk, so the candidate is 63 and it reaches nothing else.
		table_find(6'd0, 1'b0);
		table_item(MODE_ADD, 6'd63, 6'd63);
		table_item(MODE_ADD, 6'd0, 6'd63);
		table_item(MODE_FIND, 6'd0, 6'd0);
		// A single vertex is always its own mother vertex; the stored edge into
		// vertex 63 now lies beyond the count and must be ignored.
		table_cfg(7'd1);
		table_find(6'd0, 1'b1);
		table_item(MODE_ADD, 6'd0, 6'd1);
		table_cfg(7'd3);
		table_item(MODE_ADD, 6'd2, 6'd1);
		table_item(MODE_ADD, 6'd1, 6'd0);
		table_item(MODE_ADD, 6'd2, 6'd1);
		table_item(MODE_FIND, 6'd0, 6'd0);
		table_item(MODE_UNUSED, 6'd2, 6'd0);
		table_item(MODE_FIND, 6'd63, 6'd63);
		// After a clear three isolated vertices leave no mother vertex.
		table_item(MODE_CLEAR, 6'd63, 6'd63);
		table_find(6'd0, 1'b0);
		// No vertices in use: the find reports all zeros and adds are dropped.
		table_cfg(7'd0);
		table_find(6'd0, 1'b0);
		table_item(MODE_ADD, 6'd0, 6'd0);
		// A count past the store behaves as the full store.
		table_cfg(7'd127);
		table_item(MODE_ADD, 6'd5, 6'd63);
		table_item(MODE_ADD, 6'd63, 6'd5);
		table_item(MODE_FIND, 6'd0, 6'd0);
		table_cfg(7'd2);
		table_item(MODE_ADD, 6'd1, 6'd0);
		table_item(MODE_FIND, 6'd0, 6'd0);
		table_item(MODE_CLEAR, 6'd0, 6'd0);

		repeat (3)
			@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_vertex_count(directed_rows[i].vertex_count);
			else
				send_item(directed_rows[i].mode, directed_rows[i].from_vertex,
					directed_rows[i].to_vertex, directed_rows[i].typed,
					directed_rows[i].result);
		end

		// Random part, in rounds: pick a count, then run a few graph sequences
		// under it. The sender idles often, then very often, then never.
		directed_items = items_sent;
		while (items_sent < ITEM_TARGET || finds_sent < FIND_TARGET) begin
			random_span = items_sent - directed_items;
			if (random_span < (ITEM_TARGET - directed_items) / 3)
				sender_idle_pct = 36;
			else if (random_span < 2 * (ITEM_TARGET - directed_items) / 3)
				sender_idle_pct = 63;
			else
				sender_idle_pct = 0;

			pick = $urandom_range(99);
			if (pick < 5)
				next_count = 7'd0;
			else if (pick < 10)
				next_count = 7'd1;
			else if (pick < 16)
				next_count = 7'd64;
			else if (pick < 20)
				next_count = VCOUNT_W'($urandom_range(65, 127));
			else if (pick < 28)
				next_count = VCOUNT_W'($urandom_range(17, 63));
			else
				next_count = VCOUNT_W'($urandom_range(2, 16));
			write_vertex_count(next_count);

			repeat ($urandom_range(1, 3))
				build_and_search((next_count > N_VERT) ? N_VERT : next_count);
		end

		// Drain: every find must report, then a quiet spell catches stray beats.
		start <= 1'b0;
		while (pending_searches.size() != 0)
			@(negedge clk);
		repeat (4 * SETTLE_CYCLES)
			@(negedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
